@@ src/ntc_pkg.sv @@
// Shared types and constants for the nearest-to-center top-K selector.
// No dependencies; every other file imports this package.
package ntc_pkg;

    localparam int POS_W      = 24;  // world x, unsigned Q16.8
    localparam int OFF_W      = 24;  // view offset, signed Q16.8
    localparam int SCALE_W    = 12;  // view scale, unsigned Q4.8
    localparam int WIDTH_W    = 12;  // screen width
    localparam int MBASE_W    = 10;  // margin base
    localparam int FRAC_W     = 8;   // fraction bits of scale and offset
    localparam int DIST_W     = 13;
    localparam int IDX_W      = 8;
    localparam int COUNT_W    = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_VIEW_OFFSET  = 2'd0,
        CFG_VIEW_SCALE   = 2'd1,
        CFG_SCREEN_WIDTH = 2'd2,
        CFG_MARGIN_BASE  = 2'd3
    } t_cfg_reg;

    typedef enum logic [0:0] {
        BK_RUN  = 1'b0,
        BK_EMIT = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [POS_W-1:0] position_x;
        logic             last_item;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]   object_index;
        logic               entry_valid;
        logic [COUNT_W-1:0] shown_count;
        logic               last_result;
    } t_out_word;

    // Classified item passed from front to back.
    typedef struct packed {
        logic              last;
        logic              keep;   // inside the limit and not culled
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } t_cand;

endpackage

@@ src/ntc_front.sv @@
// Front end: config registers, item counter and the map / cull / distance pipeline.
// Depends on ntc_pkg.
module ntc_front #(
    parameter int MAX_ITEMS = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ntc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ntc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ntc_pkg::t_in_word          i_in_word,
    output logic                       o_cand_valid,
    input  logic                       i_cand_ready,
    output ntc_pkg::t_cand             o_cand
);
    import ntc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int PROD_W = POS_W + SCALE_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_SH = 2 * FRAC_W;
    localparam int SX_W   = SUM_W - RND_SH;
    localparam int MPR_W  = MBASE_W + SCALE_W;
    localparam int MARG_W = MPR_W - FRAC_W;
    localparam int HI_W   = MARG_W + 1;
    localparam int CMP_W  = SX_W + 2;

    localparam logic signed [SUM_W-1:0] HALF_UP = SUM_W'(1) <<< (RND_SH - 1);
    localparam logic signed [SUM_W-1:0] HALF_DN = HALF_UP - SUM_W'(1);

    // config
    logic signed [OFF_W-1:0]   r_offset;
    logic [SCALE_W-1:0]        r_scale;
    logic [WIDTH_W-1:0]        r_width;
    logic [MBASE_W-1:0]        r_mbase;
    logic [MPR_W-1:0]          r_mprod;
    logic [MARG_W-1:0]         r_margin;
    logic [HI_W-1:0]           r_hi;

    // pipeline
    logic                      r1_v, r2_v, r3_v, r4_v;
    logic [PROD_W-1:0]         r1_prod;
    logic signed [SUM_W-1:0]   r2_s;
    logic signed [SX_W-1:0]    r3_sx;
    logic                      r1_last, r2_last, r3_last;
    logic                      r1_keep, r2_keep, r3_keep;
    logic [IDX_W-1:0]          r1_idx, r2_idx, r3_idx;
    t_cand                     r4_cand;
    logic [CNT_W-1:0]          r_cnt;

    logic                      adv;
    logic                      accept;
    logic                      in_range;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [CMP_W-1:0]   sx_e, lo_lim, hi_lim, center, dist_s;
    logic                      culled;
    logic [DIST_W-1:0]         n_dist;

    assign adv        = !r4_v || i_cand_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;
    assign in_range   = r_cnt < CNT_W'(MAX_ITEMS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_scale  <= SCALE_W'(256);
            r_width  <= WIDTH_W'(320);
            r_mbase  <= MBASE_W'(80);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_VIEW_OFFSET:  r_offset <= $signed(i_cfg_data[OFF_W-1:0]);
                CFG_VIEW_SCALE:   r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_SCREEN_WIDTH: r_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_MARGIN_BASE:  r_mbase  <= i_cfg_data[MBASE_W-1:0];
                default: ;
            endcase
        end
    end

    // margin terms: the margin product is registered first, then the margin and upper limit
    always_ff @(posedge i_clk) begin
        r_mprod  <= MPR_W'(r_mbase) * MPR_W'(r_scale);
        r_margin <= r_mprod[MPR_W-1:FRAC_W];
        r_hi     <= HI_W'(r_width) + HI_W'(r_mprod[MPR_W-1:FRAC_W]);
    end

    // item counter: holds at the limit, restarts after a last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            if (i_in_word.last_item) begin
                r_cnt <= '0;
            end else if (in_range) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // round half away from zero in one add: bias is one less for negative sums
    assign n_sum = r2_s + (r2_s[SUM_W-1] ? HALF_DN : HALF_UP);

    always_comb begin
        sx_e   = CMP_W'(r3_sx);
        lo_lim = -$signed({{(CMP_W-MARG_W){1'b0}}, r_margin});
        hi_lim = $signed({{(CMP_W-HI_W){1'b0}}, r_hi});
        center = $signed({{(CMP_W-WIDTH_W+1){1'b0}}, r_width[WIDTH_W-1:1]});
        culled = (sx_e < lo_lim) || (sx_e > hi_lim);
        dist_s = (sx_e < center) ? (center - sx_e) : (sx_e - center);
        n_dist = (dist_s > $signed(CMP_W'(DIST_MAX))) ? DIST_MAX : dist_s[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_prod <= PROD_W'(i_in_word.position_x) * PROD_W'(r_scale);
            r1_last <= i_in_word.last_item;
            r1_keep <= in_range;
            r1_idx  <= IDX_W'(r_cnt);

            r2_s    <= $signed({2'b00, r1_prod})
                     + $signed({{(SUM_W-OFF_W-FRAC_W){r_offset[OFF_W-1]}}, r_offset,
                                {FRAC_W{1'b0}}});
            r2_last <= r1_last;
            r2_keep <= r1_keep;
            r2_idx  <= r1_idx;

            r3_sx   <= n_sum[SUM_W-1:RND_SH];
            r3_last <= r2_last;
            r3_keep <= r2_keep;
            r3_idx  <= r2_idx;

            r4_cand.last     <= r3_last;
            r4_cand.keep     <= r3_keep && !culled;
            r4_cand.distance <= n_dist;
            r4_cand.idx      <= r3_idx;
        end
    end

    assign o_cand_valid = r4_v;
    assign o_cand       = r4_cand;

endmodule

@@ src/ntc_queue.sv @@
// Short FIFO of classified words between front and back.
// Depends on ntc_pkg.
module ntc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ntc_pkg::t_cand i_word,
    output logic           o_valid,
    input  logic           i_ready,
    output ntc_pkg::t_cand o_word
);
    import ntc_pkg::*;

    t_cand              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               push, pop;

    assign o_ready = r_count != (Q_PTR_W+1)'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (Q_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (Q_PTR_W+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

@@ src/ntc_back.sv @@
// Back end: K-slot selection with worst-slot search, and list emission.
// Depends on ntc_pkg.
module ntc_back #(
    parameter int KEEP_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cand_valid,
    output logic              o_cand_ready,
    input  ntc_pkg::t_cand    i_cand,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ntc_pkg::t_out_word o_out_word
);
    import ntc_pkg::*;

    localparam int SLOT_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
    localparam int FILL_W = $clog2(KEEP_COUNT + 1);
    localparam int TREE_N = 1 << $clog2(KEEP_COUNT);

    logic [IDX_W-1:0]  r_slot_idx  [KEEP_COUNT];
    logic [DIST_W-1:0] r_slot_dist [KEEP_COUNT];
    logic [FILL_W-1:0] r_filled;
    logic [SLOT_W-1:0] r_emit;
    t_back_state       r_state, n_state;
    logic              r_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic [DIST_W-1:0] node_dist [1:2*TREE_N-1];
    logic [SLOT_W-1:0] node_slot [1:2*TREE_N-1];

    logic pop, emit_go, out_free, emit_last, emit_done, has_free;

    // first-largest search: ties keep the left (lower) slot
    always_comb begin
        for (int i = 0; i < TREE_N; i++) begin
            if (i < KEEP_COUNT) begin
                node_dist[TREE_N+i] = r_slot_dist[i];
                node_slot[TREE_N+i] = SLOT_W'(i);
            end else begin
                node_dist[TREE_N+i] = '0;
                node_slot[TREE_N+i] = '0;
            end
        end
        for (int n = TREE_N - 1; n >= 1; n--) begin
            if (node_dist[2*n+1] > node_dist[2*n]) begin
                node_dist[n] = node_dist[2*n+1];
                node_slot[n] = node_slot[2*n+1];
            end else begin
                node_dist[n] = node_dist[2*n];
                node_slot[n] = node_slot[2*n];
            end
        end
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign has_free  = r_filled < FILL_W'(KEEP_COUNT);
    assign emit_last = (FILL_W'(r_emit) + FILL_W'(1)) == r_filled;
    assign emit_done = (r_filled == '0) || emit_last;

    // FSM outputs
    always_comb begin
        o_cand_ready = 1'b0;
        emit_go      = 1'b0;
        case (r_state)
            BK_RUN:  o_cand_ready = 1'b1;
            BK_EMIT: emit_go      = out_free;
            default: ;
        endcase
    end

    // FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN:  if (i_cand_valid && i_cand.last) n_state = BK_EMIT;
            BK_EMIT: if (emit_go && emit_done) n_state = BK_RUN;
            default: n_state = BK_RUN;
        endcase
    end

    assign pop = i_cand_valid && o_cand_ready;

    always_comb begin
        if (r_filled == '0) begin
            n_out_word.object_index = '0;
            n_out_word.entry_valid  = 1'b0;
            n_out_word.shown_count  = '0;
            n_out_word.last_result  = 1'b1;
        end else begin
            n_out_word.object_index = r_slot_idx[r_emit];
            n_out_word.entry_valid  = 1'b1;
            n_out_word.shown_count  = COUNT_W'(r_filled);
            n_out_word.last_result  = emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cand.keep) begin
            if (has_free) begin
                r_slot_idx[SLOT_W'(r_filled)]  <= i_cand.idx;
                r_slot_dist[SLOT_W'(r_filled)] <= i_cand.distance;
            end else if (i_cand.distance < node_dist[1]) begin
                r_slot_idx[node_slot[1]]  <= i_cand.idx;
                r_slot_dist[node_slot[1]] <= i_cand.distance;
            end
        end
        if (emit_go) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_filled    <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop && i_cand.keep && has_free) begin
                r_filled <= r_filled + FILL_W'(1);
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
                if (emit_done) begin
                    r_filled <= '0;
                    r_emit   <= '0;
                end else begin
                    r_emit <= r_emit + SLOT_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ src/nearest_to_center_top_k_select.sv @@
// Top level of the nearest-to-center top-K selector: front, queue and back.
// Depends on ntc_pkg, ntc_front, ntc_queue and ntc_back.
//
//  channel  direction  handshake                  word
//  -------  ---------  -------------------------  -----------------------------------
//  input    in         i_in_valid / o_in_ready    t_in_word  (position_x, last_item)
//  output   out        o_out_valid / i_out_ready  t_out_word (index, valid, count, last)
//  config   in         i_cfg_we (no handshake)    i_cfg_addr, i_cfg_data
//
// One input word per cycle while o_in_ready is high. A word passes the front
// pipeline registers (multiply, offset add, round, cull and distance) before
// it enters the four-entry queue. The back takes a non-last word whenever one
// is offered; a last word puts it in its emit state, which takes no word until
// all result words (at least one) leave through the single output register.
// Synchronous active-low reset clears all control state and loads the config
// defaults. Output stalls fill the queue first, then stall the front via o_in_ready.
module nearest_to_center_top_k_select #(
    parameter int KEEP_COUNT = 4,
    parameter int MAX_ITEMS  = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ntc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ntc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ntc_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ntc_pkg::t_out_word             o_out_word
);
    import ntc_pkg::*;

    // front -> queue
    logic  f_valid, f_ready;
    t_cand f_word;
    // queue -> back
    logic  q_valid, q_ready;
    t_cand q_word;

    ntc_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .o_cand_valid (f_valid),
        .i_cand_ready (f_ready),
        .o_cand       (f_word)
    );

    ntc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_word  (f_word),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_word  (q_word)
    );

    ntc_back #(
        .KEEP_COUNT (KEEP_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (q_valid),
        .o_cand_ready (q_ready),
        .i_cand       (q_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

    // the front only stalls when the queue is full
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> !f_ready)
        else $error("front stalled with room in the queue");

    // a selected entry always reports a nonzero count
    a_valid_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.entry_valid |-> o_out_word.shown_count != '0)
        else $error("selected entry with zero count");

    // an empty-list word is alone: last, zero count, zero index
    a_empty_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.entry_valid |->
            o_out_word.last_result && o_out_word.shown_count == '0
            && o_out_word.object_index == '0)
        else $error("malformed empty-list word");

    // a new output word after a non-last word keeps the list count
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_word.last_result ##1 o_out_valid
            |-> o_out_word.shown_count == $past(o_out_word.shown_count))
        else $error("count changed within a list");

endmodule
